@@ rtl/event_table_dds_pwm_player_defines.svh @@
// ---------------------------------------------------------------------------
// Event table DDS PWM player: assertion macros
// Simulation builds get concurrent checks; synthesis builds get nothing.
// ---------------------------------------------------------------------------
`ifndef EVENT_TABLE_DDS_PWM_PLAYER_DEFINES_SVH
`define EVENT_TABLE_DDS_PWM_PLAYER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication on clk, off during reset
`define ETP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("etp: same-cycle check failed");
// next-cycle implication on clk, off during reset
`define ETP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("etp: next-cycle check failed");
`else
`define ETP_ASSERT_SAME(label, ante, cons)
`define ETP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/etp_pkg.sv @@
// ---------------------------------------------------------------------------
// etp_pkg
// Shared constants, types and the sine lookup for the event table player.
// ---------------------------------------------------------------------------
package etp_pkg;

  // event table geometry
  localparam int EVENT_COUNT = 64;
  localparam int POS_W       = $clog2(EVENT_COUNT + 1);
  localparam int ADDR_W      = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_PERIOD = 2'd0;
  localparam logic [1:0] REG_GAP    = 2'd1;
  localparam logic [1:0] REG_PLAYS  = 2'd2;

  // request actions
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic        tone;
    logic [31:0] step;
    logic [31:0] count;
  } entry_t;

  // sequencer to tone generator
  typedef struct packed {
    logic       tone_en;   // this tick plays a tone sample
    logic [7:0] sidx;      // sine index, top phase bits
    logic       finished;
  } tone_ctrl_t;

  // one result
  typedef struct packed {
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic        finished;
  } res_t;

  // quarter sine, round(32767*sin(2*pi*i/256)) for i = 0..64
  localparam logic [14:0] QSINE [0:64] = '{
    15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,
    15'd5602,  15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278,
    15'd11039, 15'd11793, 15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446,
    15'd16151, 15'd16846, 15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159,
    15'd20787, 15'd21403, 15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279,
    15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683,
    15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273,
    15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
    15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728,
    15'd32757, 15'd32767
  };

  // sine magnitude for an 8-bit index; the sign is idx[7]
  function automatic logic [14:0] sine_mag(input logic [7:0] idx);
    logic [6:0] q;
    logic [6:0] m;
    q = idx[6:0];
    m = (q <= 7'd64) ? q : 7'(8'd128 - {1'b0, q});
    return QSINE[m];
  endfunction

endpackage

@@ rtl/etp_ram.sv @@
// ---------------------------------------------------------------------------
// etp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module etp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // write port; read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/etp_seq.sv @@
// ---------------------------------------------------------------------------
// etp_seq
// Playback sequencer: event table, position, phase, sample and gap counters.
// Keeps the current entry and entry 0 in registers and prefetches the next.
// ---------------------------------------------------------------------------
module etp_seq import etp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [1:0]  act,
  input  logic [5:0]  idx,
  input  logic        tone,
  input  logic [31:0] step,
  input  logic [31:0] samples,
  input  logic [31:0] repeat_gap,
  input  logic [7:0]  play_count,
  output tone_ctrl_t  ctrl
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      phase_r, phase_nxt;
  logic [31:0]      left_r, left_nxt;
  logic [7:0]       plays_r, plays_nxt;
  logic [31:0]      gap_r, gap_nxt;
  logic             cur_tone_r, cur_tone_nxt;
  logic [31:0]      cur_step_r, cur_step_nxt;
  entry_t           e0_r, e0_nxt;
  logic             byp_v_r, byp_v_nxt;
  entry_t           byp_r;

  logic             we;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t           wdata, ram_q, pf;
  logic [POS_W-1:0] pos_inc, pos_adv;
  logic [31:0]      left_dec;
  logic             idx_ok;
  logic             tone_en;

  // entry table; read address always points one past the next position
  etp_ram #(.WIDTH($bits(entry_t)), .DEPTH(EVENT_COUNT)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // prefetched entry at pos_r + 1, with forwarding of a write that raced the read
  assign pf       = byp_v_r ? byp_r : ram_q;
  assign pos_adv  = pos_r + POS_W'(1);
  assign left_dec = left_r - 32'd1;
  assign idx_ok   = 32'(idx) < EVENT_COUNT;
  assign waddr    = ADDR_W'(idx);
  assign wdata    = '{tone: tone, step: step, count: samples};

  // next-state logic for one request
  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    left_nxt     = left_r;
    plays_nxt    = plays_r;
    gap_nxt      = gap_r;
    cur_tone_nxt = cur_tone_r;
    cur_step_nxt = cur_step_r;
    e0_nxt       = e0_r;
    we           = 1'b0;
    tone_en      = 1'b0;
    if (fire) begin
      unique case (act)
        ACT_WRITE: begin
          if (idx_ok) begin
            we = 1'b1;
            if (idx == 6'd0) begin
              e0_nxt = wdata;
            end
            if (32'(idx) == 32'(pos_r)) begin
              cur_tone_nxt = tone;
              cur_step_nxt = step;
            end
          end
        end
        ACT_START: begin
          pos_nxt      = '0;
          phase_nxt    = '0;
          plays_nxt    = play_count;
          left_nxt     = e0_r.count;
          gap_nxt      = '0;
          cur_tone_nxt = e0_r.tone;
          cur_step_nxt = e0_r.step;
        end
        ACT_TICK: begin
          if (gap_r != 32'd0) begin
            gap_nxt = gap_r - 32'd1;
          end else if (32'(pos_r) >= EVENT_COUNT) begin
            // end of table: start the next play after a gap while plays remain
            if (plays_r > 8'd1) begin
              plays_nxt    = plays_r - 8'd1;
              pos_nxt      = '0;
              phase_nxt    = '0;
              left_nxt     = e0_r.count;
              gap_nxt      = repeat_gap - 32'd1;
              cur_tone_nxt = e0_r.tone;
              cur_step_nxt = e0_r.step;
            end
          end else begin
            tone_en = cur_tone_r;
            if (cur_tone_r) begin
              phase_nxt = phase_r + cur_step_r;
            end
            left_nxt = left_dec;
            if (left_dec == 32'd0) begin
              pos_nxt = pos_adv;
              if (32'(pos_adv) < EVENT_COUNT) begin
                left_nxt     = pf.count;
                cur_tone_nxt = pf.tone;
                cur_step_nxt = pf.step;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // prefetch address and write forwarding
  assign pos_inc   = pos_nxt + POS_W'(1);
  assign raddr     = ADDR_W'(pos_inc);
  assign byp_v_nxt = we && (waddr == raddr);

  // result control for the tone generator
  assign ctrl.tone_en  = tone_en;
  assign ctrl.sidx     = phase_r[31:24];
  assign ctrl.finished = (32'(pos_nxt) == EVENT_COUNT) && (plays_nxt <= 8'd1);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_W'(EVENT_COUNT);
      phase_r <= '0;
      left_r  <= '0;
      plays_r <= '0;
      gap_r   <= '0;
      byp_v_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      plays_r <= plays_nxt;
      gap_r   <= gap_nxt;
      byp_v_r <= byp_v_nxt;
    end
  end

  // cached table data
  always_ff @(posedge clk) begin
    cur_tone_r <= cur_tone_nxt;
    cur_step_r <= cur_step_nxt;
    e0_r       <= e0_nxt;
    byp_r      <= wdata;
  end

endmodule

@@ rtl/etp_tone.sv @@
// ---------------------------------------------------------------------------
// etp_tone
// Sine lookup and period scaling into the complementary compare pair.
// ---------------------------------------------------------------------------
module etp_tone import etp_pkg::*; (
  input  tone_ctrl_t  ctrl,
  input  logic [15:0] period,
  output res_t        res
);

  logic [14:0] mag;
  logic [30:0] prod;
  logic [15:0] pulse;

  // magnitude is at most 32767, so no clamp stage is needed
  assign mag   = sine_mag(ctrl.sidx);
  assign prod  = 31'(mag) * 31'(period);
  assign pulse = prod[30:15];

  // negative half lowers compare_a, positive half lowers compare_b
  always_comb begin
    res.compare_a = period;
    res.compare_b = period;
    res.finished  = ctrl.finished;
    if (ctrl.tone_en) begin
      if (ctrl.sidx[7]) begin
        res.compare_a = period - pulse;
      end else begin
        res.compare_b = period - pulse;
      end
    end
  end

endmodule

@@ rtl/etp_outbuf.sv @@
// ---------------------------------------------------------------------------
// etp_outbuf
// Result register with a skid stage that catches a result accepted under stall.
// ---------------------------------------------------------------------------
module etp_outbuf import etp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  res_t res,
  input  logic out_stall,
  output logic out_valid,
  output res_t out_res,
  output logic skid_full
);

  logic out_v_r, out_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic out_free;

  assign out_free = !out_v_r || !out_stall;

  // output register loads from skid first, else from the new result
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (out_free) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        out_nxt   = res;
        out_v_nxt = fire;
      end
    end else if (fire) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign skid_full = skid_v_r;

endmodule

@@ rtl/event_table_dds_pwm_player.sv @@
// ---------------------------------------------------------------------------
// event_table_dds_pwm_player: one request per cycle while the skid is empty.
// The sequencer state and the result (output register or skid) update together.
// Throughput: 1 request per cycle; input stalls only while a result waits in the skid.
// Reset: synchronous active-low; playback idle at table end, registers 2/0/1.
// ---------------------------------------------------------------------------
`include "event_table_dds_pwm_player_defines.svh"

module event_table_dds_pwm_player import etp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [5:0]        in_entry_index,
  input  logic              in_entry_is_tone,
  input  logic [31:0]       in_entry_phase_step,
  input  logic [31:0]       in_entry_samples,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_compare_a,
  output logic [15:0]       out_compare_b,
  output logic              out_finished,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [15:0] period_r;
  logic [31:0] gap_cfg_r;
  logic [7:0]  plays_cfg_r;
  logic        cfg_wr;
  logic [1:0]  reg_idx;
  logic        fire;
  tone_ctrl_t  ctrl;
  res_t        res, out_res;
  logic        skid_full;

  // register writes
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= 16'd2;
      gap_cfg_r   <= 32'd0;
      plays_cfg_r <= 8'd1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PERIOD: period_r    <= pwdata[15:0];
        REG_GAP:    gap_cfg_r   <= pwdata;
        REG_PLAYS:  plays_cfg_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_PERIOD: prdata = CFG_DW'(period_r);
      REG_GAP:    prdata = gap_cfg_r;
      REG_PLAYS:  prdata = CFG_DW'(plays_cfg_r);
      default:    prdata = '0;
    endcase
  end

  // request accept
  assign fire = in_valid && !in_stall;

  etp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .act        (in_action),
    .idx        (in_entry_index),
    .tone       (in_entry_is_tone),
    .step       (in_entry_phase_step),
    .samples    (in_entry_samples),
    .repeat_gap (gap_cfg_r),
    .play_count (plays_cfg_r),
    .ctrl       (ctrl)
  );

  etp_tone u_tone (
    .ctrl   (ctrl),
    .period (period_r),
    .res    (res)
  );

  etp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .skid_full (skid_full)
  );

  assign in_stall      = skid_full;
  assign out_compare_a = out_res.compare_a;
  assign out_compare_b = out_res.compare_b;
  assign out_finished  = out_res.finished;

  // a parked result implies the output register is full
  `ETP_ASSERT_SAME(a_skid_needs_out, in_stall, out_valid)
  // the skid fills only behind a stalled result
  `ETP_ASSERT_SAME(a_skid_cause, $rose(in_stall), $past(out_valid && out_stall))
  // a request accepted into a free output shows up next cycle
  `ETP_ASSERT_NEXT(a_result_next, in_valid && !in_stall && (!out_valid || !out_stall),
                   out_valid)

endmodule

@@ sim/event_table_dds_pwm_player_checker.sv @@
// ----------------------------------------------------------------------------
// Event table DDS PWM player: result checker
// Watches the request, result and register ports, keeps its own model of the
// player (table, sequencer, registers), and compares each result field by
// field with the oldest predicted one. Register reads are checked as well.
// ----------------------------------------------------------------------------
module event_table_dds_pwm_player_checker import etp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [5:0]        in_entry_index,
  input  logic              in_entry_is_tone,
  input  logic [31:0]       in_entry_phase_step,
  input  logic [31:0]       in_entry_samples,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [15:0]       out_compare_a,
  input  logic [15:0]       out_compare_b,
  input  logic              out_finished,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  input  logic [CFG_DW-1:0] prdata,
  input  logic              pready,
  output int                mismatch_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies
  logic [15:0]      period_q;
  logic [31:0]      gap_reg_q;
  logic [7:0]       plays_reg_q;

  // event table
  logic             tone_tbl [EVENT_COUNT];
  logic [31:0]      step_tbl [EVENT_COUNT];
  logic [31:0]      len_tbl  [EVENT_COUNT];

  // sequencer
  logic [POS_W-1:0] pos_q;
  logic [31:0]      phase_q;
  logic [31:0]      samples_q;
  logic [31:0]      gap_q;
  logic [7:0]       plays_left_q;

  res_t             compare_fifo[$];

  function automatic logic [31:0] len_at(input logic [POS_W-1:0] pos);
    return (pos < EVENT_COUNT) ? len_tbl[ADDR_W'(pos)] : 32'd0;
  endfunction

  // apply one request to the player state and return the compare pair it gives
  function automatic res_t play_request(input logic [1:0] act, input logic [5:0] idx,
                                        input logic tone, input logic [31:0] step,
                                        input logic [31:0] len);
    logic [15:0] cmp_a;
    logic [15:0] cmp_b;
    logic [7:0]  sidx;
    logic [6:0]  q;
    logic [14:0] mag;
    logic [31:0] pulse;
    res_t        r;
    cmp_a = period_q;
    cmp_b = period_q;
    case (act)
      ACT_WRITE: begin
        if (int'(idx) < EVENT_COUNT) begin
          tone_tbl[idx] = tone;
          step_tbl[idx] = step;
          len_tbl[idx]  = len;
        end
      end
      ACT_START: begin
        pos_q        = '0;
        phase_q      = '0;
        plays_left_q = plays_reg_q;
        samples_q    = len_at('0);
        gap_q        = '0;
      end
      ACT_TICK: begin
        if (gap_q != 0) begin
          gap_q = gap_q - 1;
        end else if (pos_q >= EVENT_COUNT) begin
          // end of table: replay after the gap while plays remain
          if (plays_left_q > 8'd1) begin
            plays_left_q = plays_left_q - 8'd1;
            pos_q        = '0;
            phase_q      = '0;
            samples_q    = len_at('0);
            gap_q        = gap_reg_q - 1;
          end
        end else begin
          if (tone_tbl[ADDR_W'(pos_q)]) begin
            // sine magnitude from the top phase bits, scaled by the period
            sidx  = phase_q[31:24];
            q     = sidx[6:0];
            mag   = (q <= 7'd64) ? QSINE[q] : QSINE[7'(8'd128 - {1'b0, q})];
            pulse = (32'(mag) * 32'(period_q)) >> 15;
            if (sidx[7]) cmp_a = cmp_a - pulse[15:0];
            else cmp_b = cmp_b - pulse[15:0];
            phase_q = phase_q + step_tbl[ADDR_W'(pos_q)];
          end
          samples_q = samples_q - 1;
          if (samples_q == 0) begin
            pos_q = pos_q + POS_W'(1);
            if (pos_q < EVENT_COUNT) samples_q = len_at(pos_q);
          end
        end
      end
      default: ;
    endcase
    r.compare_a = cmp_a;
    r.compare_b = cmp_b;
    r.finished  = (pos_q == POS_W'(EVENT_COUNT)) && (plays_left_q <= 8'd1);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  initial mismatch_count = 0;

  // sample all channels at the rising edge
  always @(posedge clk) begin
    res_t        got_res;
    res_t        want_res;
    logic [31:0] reg_val;
    if (!rst_n) begin
      period_q     = 16'd2;
      gap_reg_q    = 32'd0;
      plays_reg_q  = 8'd1;
      pos_q        = POS_W'(EVENT_COUNT);
      phase_q      = '0;
      samples_q    = '0;
      gap_q        = '0;
      plays_left_q = '0;
      compare_fifo.delete();
    end else begin
      // register port
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_PERIOD: period_q    = pwdata[15:0];
            REG_GAP:    gap_reg_q   = pwdata[31:0];
            REG_PLAYS:  plays_reg_q = pwdata[7:0];
            default: ;
          endcase
        end else if (paddr[3:2] inside {REG_PERIOD, REG_GAP, REG_PLAYS}) begin
          case (paddr[3:2])
            REG_PERIOD: reg_val = {16'd0, period_q};
            REG_GAP:    reg_val = gap_reg_q;
            default:    reg_val = {24'd0, plays_reg_q};
          endcase
          if (prdata !== reg_val)
            flag_error($sformatf("register %0d read: exp %h got %h",
                                 paddr[3:2], reg_val, prdata));
        end
      end
      // accepted request
      if (in_valid && !in_stall)
        compare_fifo.push_back(play_request(in_action, in_entry_index, in_entry_is_tone,
                                            in_entry_phase_step, in_entry_samples));
      // accepted result
      if (out_valid && !out_stall) begin
        got_res.compare_a = out_compare_a;
        got_res.compare_b = out_compare_b;
        got_res.finished  = out_finished;
        if (compare_fifo.size() == 0) begin
          flag_error($sformatf("result with none expected: a=%h b=%h fin=%b",
                               got_res.compare_a, got_res.compare_b, got_res.finished));
        end else begin
          want_res = compare_fifo.pop_front();
          if (got_res.compare_a !== want_res.compare_a ||
              got_res.compare_b !== want_res.compare_b ||
              got_res.finished !== want_res.finished)
            flag_error($sformatf("result: exp a=%h b=%h fin=%b got a=%h b=%h fin=%b",
                                 want_res.compare_a, want_res.compare_b, want_res.finished,
                                 got_res.compare_a, got_res.compare_b, got_res.finished));
        end
      end
    end
    pending <= compare_fifo.size();
  end

endmodule

@@ sim/tb_event_table_dds_pwm_player.sv @@
// ----------------------------------------------------------------------------
// Event table DDS PWM player: testbench top
// Loads the event table, runs a short directed sequence (sine sweep, restart,
// idle and unused actions), then random playback phases under several
// register settings, most with random gaps and output stalls. The checker
// predicts and compares; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_event_table_dds_pwm_player;
  timeunit 1ns;
  timeprecision 1ps;
  import etp_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         RUN_LIMIT   = 500000;
  localparam int         DRAIN_LIMIT = 20000;
  localparam int         PHASES      = 7;
  localparam int         PHASE_REQS  = 140;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_action;
  logic [5:0]        in_entry_index;
  logic              in_entry_is_tone;
  logic [31:0]       in_entry_phase_step;
  logic [31:0]       in_entry_samples;
  logic              out_valid;
  logic              out_stall;
  logic [15:0]       out_compare_a;
  logic [15:0]       out_compare_b;
  logic              out_finished;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int                mismatch_count;
  int                pending;
  int                cycle_count;
  int                stall_run;
  logic              burst;            // no gaps or stalls in this phase
  logic [31:0]       len_shadow [EVENT_COUNT];

  event_table_dds_pwm_player u_dut (.*);

  event_table_dds_pwm_player_checker u_checker (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // random output stalls
  initial begin
    out_stall = 1'b0;
    stall_run = 0;
    forever begin
      @(negedge clk);
      if (stall_run > 0) stall_run--;
      else if (!burst && $urandom_range(0, 3) == 0) stall_run = pick_gap();
      out_stall <= (stall_run > 0);
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [31:0] short_len();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(2, 3) : 32'd1;
  endfunction

  // event length: mostly short, sometimes zero (wraps) or huge
  function automatic logic [31:0] event_len();
    int r;
    r = $urandom_range(0, 49);
    if (r == 0) return 32'd0;
    if (r == 1) return $urandom;
    return short_len();
  endfunction

  task automatic send(input logic [1:0] act, input logic [5:0] idx, input logic tone,
                      input logic [31:0] step, input logic [31:0] len);
    @(negedge clk);
    in_valid            <= 1'b1;
    in_action           <= act;
    in_entry_index      <= idx;
    in_entry_is_tone    <= tone;
    in_entry_phase_step <= step;
    in_entry_samples    <= len;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (act == ACT_WRITE) len_shadow[idx] = len;
  endtask

  task automatic idle_gap();
    int n;
    n = 0;
    if (!burst && $urandom_range(0, 2) == 0) n = pick_gap();
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_noise(input logic [1:0] act);
    send(act, 6'($urandom), 1'($urandom), $urandom, $urandom);
    idle_gap();
  endtask

  task automatic write_entry(input logic [5:0] idx, input logic [31:0] len);
    send(ACT_WRITE, idx, 1'($urandom), $urandom, len);
    idle_gap();
  endtask

  task automatic reg_access(input logic wr, input logic [1:0] ridx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {ridx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // set all registers and read them back
  task automatic program_regs(input logic [15:0] per, input logic [31:0] gap,
                              input logic [7:0] plays);
    reg_access(1'b1, REG_PERIOD, {16'd0, per});
    reg_access(1'b1, REG_GAP, gap);
    reg_access(1'b1, REG_PLAYS, {24'd0, plays});
    reg_access(1'b0, REG_PERIOD, '0);
    reg_access(1'b0, REG_GAP, '0);
    reg_access(1'b0, REG_PLAYS, '0);
  endtask

  // wait until every request has its result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // one random request: mostly ticks, some table rewrites, rare restarts
  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) send_noise(ACT_TICK);
    else if (pick < 96) write_entry(6'($urandom), event_len());
    else if (pick < 98) send_noise(ACT_START);
    else send_noise(ACT_UNUSED);
  endtask

  initial begin
    logic [15:0] per;
    logic [31:0] gap;
    logic [7:0]  plays;
    int          waited;
    rst_n               = 1'b0;
    burst               = 1'b0;
    in_valid            = 1'b0;
    in_action           = ACT_TICK;
    in_entry_index      = '0;
    in_entry_is_tone    = 1'b0;
    in_entry_phase_step = '0;
    in_entry_samples    = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values, then a wide period
    reg_access(1'b0, REG_PERIOD, '0);
    reg_access(1'b0, REG_GAP, '0);
    reg_access(1'b0, REG_PLAYS, '0);
    program_regs(16'hFFFF, 32'd2, 8'd2);

    // load every entry; entry 0 sweeps just over half a sine cycle
    for (int i = 0; i < EVENT_COUNT; i++) begin
      case (i)
        0:       send(ACT_WRITE, 6'd0, 1'b1, 32'h0800_0000, 32'd17);
        1:       send(ACT_WRITE, 6'd1, 1'b0, 32'hFFFF_FFFF, 32'd2);
        2:       send(ACT_WRITE, 6'd2, 1'b1, 32'hFFFF_FFFF, 32'd3);
        default: send(ACT_WRITE, 6'(i), 1'($urandom), $urandom, short_len());
      endcase
      idle_gap();
    end

    // directed: idle tick, unused action, sweep, restart mid-play
    send_noise(ACT_TICK);
    send_noise(ACT_UNUSED);
    send_noise(ACT_START);
    repeat (18) send_noise(ACT_TICK);
    send_noise(ACT_START);
    repeat (2) send_noise(ACT_TICK);
    drain();

    // random playback phases under varied settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin per = 16'd2;     gap = 32'd0; plays = 8'd1; end
        1: begin per = 16'hFFFF;  gap = 32'd1; plays = 8'd3; end
        2: begin per = 16'd0;     gap = 32'd3; plays = 8'd0; end
        3: begin per = 16'd1;     gap = 32'd0; plays = 8'd2; end
        4: begin
          per   = 16'($urandom_range(2, 65535));
          gap   = $urandom_range(0, 5);
          plays = 8'd255;
        end
        5: begin
          per   = 16'($urandom_range(2, 65535));
          gap   = 32'hFFFF_FFFF;
          plays = 8'd2;
        end
        default: begin
          per   = 16'($urandom_range(2, 65535));
          gap   = $urandom_range(1, 4);
          plays = 8'($urandom_range(1, 3));
        end
      endcase
      burst = (ph == 1 || ph == 4);
      program_regs(per, gap, plays);
      // shorten entries left with zero or huge lengths
      for (int i = 0; i < EVENT_COUNT; i++)
        if (len_shadow[i] == 0 || len_shadow[i] > 3) write_entry(6'(i), short_len());
      send_noise(ACT_START);
      repeat (PHASE_REQS) random_request();
      drain();
    end

    // final drain and verdict
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ event_table_dds_pwm_player.f @@
+incdir+rtl
rtl/etp_pkg.sv
rtl/etp_ram.sv
rtl/etp_seq.sv
rtl/etp_tone.sv
rtl/etp_outbuf.sv
rtl/event_table_dds_pwm_player.sv
sim/event_table_dds_pwm_player_checker.sv
sim/tb_event_table_dds_pwm_player.sv
